>>> design/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Table geometry
    localparam int unsigned TABLE_SLOTS = 1024;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int unsigned COUNT_W     = $clog2(TABLE_SLOTS + 1);

    // Fixed field widths of the request and response
    localparam int unsigned KEY_W         = 31;
    localparam int unsigned SLOT_OUT_W    = 10;
    localparam int unsigned ENTRY_COUNT_W = 11;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_OUT_W-1:0]    slot;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } resp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

    localparam int unsigned ENTRY_W = $bits(slot_entry_t);

    // Slot RAM command from the probe engine
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_entry_t       wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } mem_cmd_t;

    // Circular successor of a slot index
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(TABLE_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lpht_probe.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_probe (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 hash_select,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire lpht_pkg::req_t       s_req,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lpht_pkg::resp_t           m_resp,
    output lpht_pkg::mem_cmd_t        mem_cmd,
    input  wire lpht_pkg::slot_entry_t mem_rdata
);

    import lpht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    resp_t              out_reg, out_next;

    req_t               req_reg, req_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;       // next read address
    logic [SLOT_W-1:0]  data_slot_reg, data_slot_next; // slot of returning data
    logic [SLOT_W-1:0]  data_cnt_reg, data_cnt_next;   // probe distance
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  hit_slot_reg, hit_slot_next;

    logic              accept;
    logic              out_free;
    logic              match;
    logic              valid_code;
    logic [SLOT_W-1:0] home;

    function automatic logic [SLOT_W-1:0] home_slot(input logic sel,
                                                     input logic [KEY_W-1:0] k);
        logic [31:0] kw;
        kw = 32'(k);
        if (sel) begin
            return SLOT_W'((kw / TABLE_SLOTS) % TABLE_SLOTS);
        end
        return SLOT_W'(kw % TABLE_SLOTS);
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign home     = home_slot(hash_select, s_req.key);
    assign m_valid  = out_valid_reg;
    assign m_resp   = out_reg;

    assign valid_code = (s_req.req_type == REQ_INSERT) || (s_req.req_type == REQ_SEARCH)
                     || (s_req.req_type == REQ_DELETE);

    // Insert wants an empty slot, search and delete want the key
    always_comb begin
        if (req_reg.req_type == REQ_INSERT) begin
            match = !mem_rdata.valid;
        end else begin
            match = mem_rdata.valid && (mem_rdata.key == req_reg.key);
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        data_slot_next = data_slot_reg;
        data_cnt_next  = data_cnt_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;

        mem_cmd.we    = 1'b0;
        mem_cmd.waddr = clr_addr_reg;
        mem_cmd.wdata = '0;
        mem_cmd.re    = 1'b0;
        mem_cmd.raddr = addr_reg;

        unique case (state_reg)
            S_CLEAR: begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = clr_addr_reg;
                clr_addr_next = next_slot(clr_addr_reg);
                if (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    req_next       = s_req;
                    hit_next       = 1'b0;
                    mem_cmd.re     = 1'b1;
                    mem_cmd.raddr  = home;
                    addr_next      = next_slot(home);
                    data_slot_next = home;
                    data_cnt_next  = '0;
                    state_next     = valid_code ? S_PROBE : S_FINISH;
                end
            end
            S_PROBE: begin
                mem_cmd.re     = 1'b1;
                mem_cmd.raddr  = addr_reg;
                addr_next      = next_slot(addr_reg);
                data_slot_next = next_slot(data_slot_reg);
                data_cnt_next  = data_cnt_reg + SLOT_W'(1);
                if (match) begin
                    hit_next      = 1'b1;
                    hit_slot_next = data_slot_reg;
                    state_next    = S_FINISH;
                end else if (data_cnt_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    mem_cmd.waddr = hit_slot_reg;
                    if (hit_reg && (req_reg.req_type == REQ_INSERT)) begin
                        mem_cmd.we        = 1'b1;
                        mem_cmd.wdata.valid = 1'b1;
                        mem_cmd.wdata.key = req_reg.key;
                        count_next        = count_reg + COUNT_W'(1);
                    end else if (hit_reg && (req_reg.req_type == REQ_DELETE)) begin
                        mem_cmd.we = 1'b1;
                        count_next = count_reg - COUNT_W'(1);
                    end
                    out_valid_next       = 1'b1;
                    out_next.entry_count = ENTRY_COUNT_W'(count_next);
                    if (hit_reg) begin
                        out_next.status = ST_OK;
                        out_next.slot   = SLOT_OUT_W'(hit_slot_reg);
                    end else begin
                        out_next.status = (req_reg.req_type == REQ_INSERT) ? ST_FULL
                                                                           : ST_NOT_FOUND;
                        out_next.slot   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        data_slot_reg <= data_slot_next;
        data_cnt_reg  <= data_cnt_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
    end

endmodule

`default_nettype wire

>>> design/linear_probe_hash_table.sv
// Probing: a request whose match (or empty slot) lies k slots past home reads the
//   slots from home up to home + k; a miss scans all 1024 slots.
// Throughput: one request at a time, through the single slot RAM read port;
//   a response still waiting holds the next request in its finish state until taken.
// Reset: synchronous, active low; a clearing pass then empties all 1024 slots of the
//   slot RAM, with requests held off meanwhile (register writes still taken).
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // register write channel: hash_select
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data,
    // request channel
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lpht_pkg::req_t s_req,
    // response channel
    output logic                m_valid,
    input  wire logic           m_ready,
    output lpht_pkg::resp_t     m_resp
);

    import lpht_pkg::*;

    // hash_select: 0 takes the low key bits as home, 1 the next slot-index bits up
    logic hash_select_reg;

    mem_cmd_t          mem_cmd;
    logic [ENTRY_W-1:0] mem_rdata;

    // Register writes are only legal while idle, so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_select_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            hash_select_reg <= cfg_data;
        end
    end

    // Slot store: valid flag and key per slot, one read and one write port
    lpht_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (mem_rdata)
    );

    // Probe engine: clears the RAM after reset, then runs one request at a time,
    // reading one slot per cycle and writing back at most once at the end
    lpht_probe u_probe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hash_select (hash_select_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resp      (m_resp),
        .mem_cmd     (mem_cmd),
        .mem_rdata   (slot_entry_t'(mem_rdata))
    );

    // Failed requests report slot zero
    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_resp.status != ST_OK) |-> (m_resp.slot == '0))
        else $error("non-zero slot on failed request");

    // Write-back never overlaps a probe read
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_cmd.we && mem_cmd.re))
        else $error("slot RAM read and write in the same cycle");

    // One request in flight: ready drops after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one in flight");

    // Stored count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_resp.entry_count) <= TABLE_SLOTS))
        else $error("entry count exceeds table size");

endmodule

`default_nettype wire

>>> verif/lpht_response_checker.sv
`timescale 1ns / 1ps

module lpht_response_checker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    input  wire logic            cfg_ready,
    input  wire logic            cfg_data,
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  wire lpht_pkg::req_t  s_req,
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  wire lpht_pkg::resp_t m_resp,
    output int                   mismatch_count,
    output int                   outstanding,
    output int                   requests_seen,
    output int                   responses_seen,
    output int                   full_seen,
    output int                   not_found_seen,
    output int                   cfg_writes_seen
);

    import lpht_pkg::*;

    // shadow table
    logic             slot_used [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key  [TABLE_SLOTS];
    int unsigned      stored_keys;
    logic             hash_sel;

    resp_t            due_resps [$];

    function automatic int unsigned home_of(input logic [KEY_W-1:0] key);
        int unsigned k;
        k = key;
        if (hash_sel) begin
            return (k / TABLE_SLOTS) % TABLE_SLOTS;
        end
        return k % TABLE_SLOTS;
    endfunction

    // applies one request to the shadow table and returns its response
    function automatic resp_t apply_request(input req_t r);
        resp_t       rsp;
        int unsigned home;
        int unsigned idx;
        logic        hit;
        rsp.status      = ST_NOT_FOUND;
        rsp.slot        = '0;
        rsp.entry_count = '0;
        home            = home_of(r.key);
        hit             = 1'b0;
        case (r.req_type)
            REQ_INSERT: begin
                rsp.status = ST_FULL;
                for (int k = 0; k < TABLE_SLOTS && !hit; k++) begin
                    idx = (home + k) % TABLE_SLOTS;
                    if (!slot_used[idx]) begin
                        slot_used[idx] = 1'b1;
                        slot_key[idx]  = r.key;
                        stored_keys++;
                        rsp.status = ST_OK;
                        rsp.slot   = SLOT_OUT_W'(idx);
                        hit        = 1'b1;
                    end
                end
            end
            REQ_SEARCH, REQ_DELETE: begin
                // full circular scan, empty slots do not end it
                for (int k = 0; k < TABLE_SLOTS && !hit; k++) begin
                    idx = (home + k) % TABLE_SLOTS;
                    if (slot_used[idx] && slot_key[idx] == r.key) begin
                        if (r.req_type == REQ_DELETE) begin
                            slot_used[idx] = 1'b0;
                            slot_key[idx]  = '0;
                            stored_keys--;
                        end
                        rsp.status = ST_OK;
                        rsp.slot   = SLOT_OUT_W'(idx);
                        hit        = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.entry_count = ENTRY_COUNT_W'(stored_keys);
        return rsp;
    endfunction

    always @(posedge aclk) begin
        resp_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
            end
            stored_keys     = 0;
            hash_sel        = 1'b0;
            due_resps.delete();
            mismatch_count  = 0;
            outstanding     = 0;
            requests_seen   = 0;
            responses_seen  = 0;
            full_seen       = 0;
            not_found_seen  = 0;
            cfg_writes_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hash_sel = cfg_data;
                cfg_writes_seen++;
            end
            // responses first: a response never belongs to a request taken on the same edge
            if (m_valid && m_ready) begin
                responses_seen++;
                if (due_resps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] unexpected response: status %0d slot %0d count %0d",
                                 $time, m_resp.status, m_resp.slot, m_resp.entry_count);
                    end
                end else begin
                    want = due_resps.pop_front();
                    if (m_resp.status !== want.status || m_resp.slot !== want.slot ||
                        m_resp.entry_count !== want.entry_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"[%0t] response mismatch: status exp %0d got %0d, ",
                                      "slot exp %0d got %0d, count exp %0d got %0d"},
                                     $time, want.status, m_resp.status, want.slot,
                                     m_resp.slot, want.entry_count, m_resp.entry_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_request(s_req);
                due_resps.insert(due_resps.size(), want);
                requests_seen++;
                if (want.status == ST_FULL) begin
                    full_seen++;
                end
                if (want.status == ST_NOT_FOUND) begin
                    not_found_seen++;
                end
            end
            outstanding = due_resps.size();
        end
    end

endmodule

>>> verif/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the hash table. The checker beside the block keeps its own
// copy of the table and compares every response; this module only drives requests,
// register writes and back-pressure, and reads the checker's counts to drain and at the end.
module linear_probe_hash_table_tb;

    import lpht_pkg::*;

    // request code the block must treat as a no-op
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam int unsigned KEY_MAX       = 32'h7FFF_FFFF;
    localparam int          RANDOM_ITEMS  = 200;
    localparam int          SEGMENTS      = 4;
    // longest response is a full scan of the table
    localparam int          SETTLE_CYCLES = 1100;
    // ~1200 requests, each at worst a full scan plus stalls and gaps, taken a few times over
    localparam int          CYCLE_LIMIT   = 6_000_000;

    // receiver back-pressure styles
    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  cfg_valid = 1'b0;
    logic  cfg_data  = 1'b0;
    logic  s_valid   = 1'b0;
    req_t  s_req     = '0;
    logic  m_ready   = 1'b0;
    logic  cfg_ready;
    logic  s_ready;
    logic  m_valid;
    resp_t m_resp;

    int mismatches;
    int outstanding;
    int n_requests;
    int n_responses;
    int n_full;
    int n_not_found;
    int n_cfg_writes;

    // keys the stimulus believes are stored; used only to pick hits and misses
    int unsigned live_keys [$];
    int          burst_left  = 0;
    int          cycle_count = 0;

    rx_mode_e    rx_mode    = RX_OPEN;
    int          rx_left    = 0;
    logic [7:0]  rx_pattern = 8'hFF;

    linear_probe_hash_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_resp    (m_resp)
    );

    lpht_response_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req           (s_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_resp          (m_resp),
        .mismatch_count  (mismatches),
        .outstanding     (outstanding),
        .requests_seen   (n_requests),
        .responses_seen  (n_responses),
        .full_seen       (n_full),
        .not_found_seen  (n_not_found),
        .cfg_writes_seen (n_cfg_writes)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost response ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("linear_probe_hash_table_tb: errors");
        $finish;
    end

    // Receiver: switches between back-pressure styles at random, so stalls
    // land on every phase of a probe run, with open stretches in between.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode    = rx_mode_e'($urandom_range(0, 3));
            rx_left    = $urandom_range(50, 300);
            rx_pattern = $urandom;
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= $urandom_range(0, 1);
            end
            RX_PATTERN: begin
                m_ready    <= rx_pattern[0];
                rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
            end
            default: begin
                m_ready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    // Sender pacing: bursts of random length, each followed by a random gap (sometimes
    // none). Called at a falling edge before a request is presented; valid is only
    // lowered here when a gap is really taken.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    // Present one request and hold it until taken; returns on the following falling edge.
    task automatic send(input logic [1:0] op, input int unsigned key);
        req_t r;
        r.req_type = op;
        r.key      = key[KEY_W-1:0];
        pace();
        s_req   <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every outstanding response.
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Register write; only issued while no request is in flight.
    task automatic cfg_write(input logic v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int key_pos(input int unsigned key);
        for (int i = 0; i < live_keys.size(); i++) begin
            if (live_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic do_insert(input int unsigned key);
        send(REQ_INSERT, key);
        if (live_keys.size() < TABLE_SLOTS) begin
            live_keys.insert(live_keys.size(), key);
        end
    endtask

    task automatic do_delete(input int unsigned key);
        int pos;
        send(REQ_DELETE, key);
        pos = key_pos(key);
        if (pos >= 0) begin
            live_keys.delete(pos);
        end
    endtask

    // Slot index bunched near either end of the table, so runs pile up and wrap.
    function automatic int unsigned clustered_slot();
        int unsigned base;
        base = ($urandom_range(0, 1) == 0) ? 0 : TABLE_SLOTS - 16;
        return (base + $urandom_range(0, 23)) % TABLE_SLOTS;
    endfunction

    function automatic int unsigned fresh_key();
        int unsigned k;
        case ($urandom_range(0, 9))
            0: begin
                k = ($urandom_range(0, 3) == 0) ? KEY_MAX : $urandom_range(0, 2 * TABLE_SLOTS);
            end
            1, 2, 3, 4: begin
                // clustered home under both hash selections
                k = ($urandom << (2 * SLOT_W)) | (clustered_slot() << SLOT_W) | clustered_slot();
            end
            default: begin
                k = $urandom;
            end
        endcase
        return k & KEY_MAX;
    endfunction

    function automatic int unsigned absent_key();
        int unsigned k;
        k = fresh_key();
        while (key_pos(k) >= 0) begin
            k = fresh_key();
        end
        return k;
    endfunction

    // One random request: mostly hits on stored keys and inserts, a few misses (each a
    // full scan) and the odd unused code. The insert share falls as the table fills.
    task automatic random_request();
        int          n;
        int          roll;
        int          ins_pct;
        int unsigned k;
        n       = live_keys.size();
        roll    = $urandom_range(0, 99);
        ins_pct = (n < 64) ? 70 : ((n > 700) ? 20 : 45);
        if (roll < ins_pct) begin
            do_insert(fresh_key());
        end else if (roll < 94 && n != 0) begin
            k = live_keys[$urandom_range(0, n - 1)];
            if ($urandom_range(0, 2) == 0) begin
                do_delete(k);
            end else begin
                send(REQ_SEARCH, k);
            end
        end else if (roll < 98) begin
            send(($urandom_range(0, 1) == 0) ? REQ_SEARCH : REQ_DELETE, absent_key());
        end else begin
            send(REQ_UNUSED, $urandom & KEY_MAX);
        end
    endtask

    initial begin
        int pos;

        // reset held low from the start, released on a falling edge; the block then clears its
        // slot RAM while requests are held off, which the handshake absorbs
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // register writes are taken during the clearing pass
        cfg_write(1'b0);

        // Directed, modulo hash: collisions at the top slot wrapping to the bottom,
        // duplicates, wrapped search and delete, misses, unused code, empty table.
        do_insert(0);
        do_insert(KEY_MAX);
        do_insert(TABLE_SLOTS - 1);
        do_insert(0);
        send(REQ_SEARCH, TABLE_SLOTS - 1);
        send(REQ_SEARCH, 0);
        do_delete(0);
        send(REQ_SEARCH, 0);
        do_delete(TABLE_SLOTS - 1);
        send(REQ_SEARCH, 5);
        do_delete(5);
        send(REQ_UNUSED, KEY_MAX);
        do_insert(2 * TABLE_SLOTS);
        send(REQ_SEARCH, KEY_MAX);
        do_delete(KEY_MAX);
        do_delete(0);
        do_delete(2 * TABLE_SLOTS);
        send(REQ_SEARCH, 0);

        // Directed, upper-bits hash: same wrap at the top slot from the other selection.
        drain();
        cfg_write(1'b1);
        do_insert(KEY_MAX);
        do_insert(TABLE_SLOTS - 1);
        do_insert(KEY_MAX & ~(TABLE_SLOTS - 1));
        send(REQ_SEARCH, KEY_MAX & ~(TABLE_SLOTS - 1));
        do_delete(KEY_MAX & ~(TABLE_SLOTS - 1));

        // Random mix in segments, alternating the hash selection while the table is idle;
        // stored keys survive a change of hash since searches scan the whole table.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            cfg_write(1'(seg % 2));
            repeat (RANDOM_ITEMS / SEGMENTS) random_request();
        end

        // Fill to capacity, then overfill, free one slot and refill it.
        drain();
        cfg_write(1'b0);
        while (live_keys.size() < TABLE_SLOTS) begin
            do_insert(fresh_key());
        end
        do_insert(fresh_key());
        do_insert(KEY_MAX);
        send(REQ_SEARCH, live_keys[$urandom_range(0, TABLE_SLOTS - 1)]);
        pos = $urandom_range(0, TABLE_SLOTS - 1);
        do_delete(live_keys[pos]);
        do_insert(KEY_MAX);
        send(REQ_SEARCH, absent_key());
        send(REQ_UNUSED, 0);

        // wait out every response, then a full-scan's worth to catch strays
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("%0d requests, %0d responses (%0d not found, %0d table full)",
                 n_requests, n_responses, n_not_found, n_full);
        $display("%0d register writes; covered: corner keys, wrapped probes, both hashes, full",
                 n_cfg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("linear_probe_hash_table_tb: clean");
        end else begin
            $display("linear_probe_hash_table_tb: errors");
        end
        $finish;
    end

endmodule
